>>> hdl/tccw_pkg.sv
package tccw_pkg;

    // Fixed field widths of the stream words
    localparam int MODE_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;
    localparam int ATTR_W   = 8;

    // Width of the shared index unit operands (covers the address field)
    localparam int IDX_W = 13;

    // Operation modes
    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CHAR_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR  = 8'd13;

    localparam logic [CHAR_W-1:0] BLANK_GLYPH = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'd27;
    localparam int                TAB_STEP    = 8;

    // Request to the shared index unit
    typedef struct packed {
        logic [IDX_W-1:0] base;
        logic             add_row;
    } step_req_t;

    // Answer from the shared index unit
    typedef struct packed {
        logic [IDX_W-1:0] sum;
        logic [IDX_W-1:0] nxt;
        logic             in_range;
        logic             last;
    } step_rsp_t;

endpackage

>>> hdl/tccw_ram.sv
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/tccw_step_unit.sv
module tccw_step_unit #(
    parameter int CELLS   = 2000,
    parameter int COLUMNS = 80
) (
    input  tccw_pkg::step_req_t req,
    output tccw_pkg::step_rsp_t rsp
);

    localparam int IW = tccw_pkg::IDX_W;

    logic [IW-1:0] offset;

    // Offset by one row when asked, step by one, check against the screen size
    always_comb begin
        offset       = req.add_row ? IW'(COLUMNS) : '0;
        rsp.sum      = req.base + offset;
        rsp.nxt      = req.base + IW'(1);
        rsp.in_range = (rsp.sum < IW'(CELLS));
        rsp.last     = (req.base == IW'(CELLS - 1));
    end

endmodule

>>> hdl/text_console_cell_writer_core.sv
// Text console cell writer: a ROWS x COLUMNS screen of 16-bit cells (glyph in the
// low byte, attribute in the high byte) with a cursor, held in one single-port-write
// RAM. Every input word gives exactly one result word. Put character and read cell
// step through accept, one RAM access and result; the unused mode through accept
// and result. For a put that scrolls and for a clear, the sequencer moves or blanks
// one cell per cycle through the RAM write port with a shared index unit stepping
// the addresses. After reset the block sweeps the RAM to blank it and keeps s_tready
// low meanwhile; attribute writes are taken at any time. s_tready is high only while
// the sequencer is idle; a finished result waits in the output register without
// blocking the next word.
module text_console_cell_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Attribute register
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] mode, [9:2] char_code, [20:10] cell_address
    // Result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [10:0] cursor_position, [26:11] cell_value, [27] scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int IW    = tccw_pkg::IDX_W;
    localparam int VW    = tccw_pkg::CELL_W;

    typedef enum logic [7:0] {
        ST_INIT   = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_PUT    = 8'b0000_0100,
        ST_READ   = 8'b0000_1000,
        ST_CLEAR  = 8'b0001_0000,
        ST_SCROLL = 8'b0010_0000,
        ST_FLUSH  = 8'b0100_0000,
        ST_DONE   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0] idx_reg, idx_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [7:0]    attr_reg, attr_next;

    logic [tccw_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [tccw_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                        in_range_reg, in_range_next;
    logic                        scrolled_reg, scrolled_next;

    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_addr_reg, pend_addr_next;
    logic          pend_copy_reg, pend_copy_next;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;

    tccw_pkg::step_req_t step_req;
    tccw_pkg::step_rsp_t step_rsp;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [VW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [VW-1:0] ram_rdata;

    logic [VW-1:0] blank_cur;
    logic [VW-1:0] blank_rst;
    logic [AW-1:0] cur_idx;
    logic [IW-1:0] cur_pos;
    logic [VW-1:0] out_value;

    // Character put results
    logic          put_we;
    logic [AW-1:0] put_addr;
    logic [VW-1:0] put_data;
    logic [CW:0]   put_col_n;
    logic [RW:0]   put_row_n;
    logic [CW:0]   put_col_w;
    logic [RW:0]   put_row_w;
    logic          put_scroll;

    assign blank_cur = {attr_reg, tccw_pkg::BLANK_GLYPH};
    assign blank_rst = {tccw_pkg::RESET_ATTR, tccw_pkg::BLANK_GLYPH};
    assign cur_idx   = AW'(row_reg) * AW'(COLUMNS) + AW'(col_reg);
    assign cur_pos   = IW'(cur_idx);

    tccw_step_unit #(
        .CELLS   (CELLS),
        .COLUMNS (COLUMNS)
    ) u_step (
        .req (step_req),
        .rsp (step_rsp)
    );

    tccw_ram #(
        .WIDTH (VW),
        .DEPTH (CELLS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Work out the cursor move and cell write of one put
    always_comb begin
        put_we    = 1'b0;
        put_addr  = cur_idx;
        put_data  = blank_cur;
        put_col_n = {1'b0, col_reg};
        put_row_n = {1'b0, row_reg};
        unique case (char_reg)
            tccw_pkg::CHAR_LF: begin
                put_col_n = '0;
                put_row_n = {1'b0, row_reg} + (RW+1)'(1);
            end
            tccw_pkg::CHAR_CR: begin
                put_col_n = '0;
            end
            tccw_pkg::CHAR_TAB: begin
                put_col_n = ({1'b0, col_reg} + (CW+1)'(tccw_pkg::TAB_STEP))
                          & ~(CW+1)'(tccw_pkg::TAB_STEP - 1);
            end
            tccw_pkg::CHAR_BS: begin
                if (col_reg != '0) begin
                    put_col_n = {1'b0, col_reg} - (CW+1)'(1);
                    put_we    = 1'b1;
                    put_addr  = cur_idx - AW'(1);
                end
            end
            default: begin
                put_we    = 1'b1;
                put_data  = {attr_reg, char_reg};
                put_col_n = {1'b0, col_reg} + (CW+1)'(1);
            end
        endcase
        // Wrap past the last column
        if (put_col_n >= (CW+1)'(COLUMNS)) begin
            put_col_w = '0;
            put_row_w = put_row_n + (RW+1)'(1);
        end else begin
            put_col_w = put_col_n;
            put_row_w = put_row_n;
        end
        put_scroll = (put_row_w >= (RW+1)'(ROWS));
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        attr_next      = cfg_wr_en ? cfg_wr_data : attr_reg;
        char_next      = char_reg;
        addr_next      = addr_reg;
        in_range_next  = in_range_reg;
        scrolled_next  = scrolled_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_copy_next = pend_copy_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        step_req.base    = IW'(idx_reg);
        step_req.add_row = 1'b0;

        ram_re    = 1'b0;
        ram_raddr = step_rsp.sum[AW-1:0];

        // Write port: drain a pending scroll word first, then sweeps, then puts
        if (pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_copy_reg ? ram_rdata : blank_cur;
        end else if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = idx_reg;
            ram_wdata = (state_reg == ST_INIT) ? blank_rst : blank_cur;
        end else begin
            ram_we    = (state_reg == ST_PUT) && put_we;
            ram_waddr = put_addr;
            ram_wdata = put_data;
        end

        unique case (state_reg)
            ST_INIT: begin
                idx_next = step_rsp.nxt[AW-1:0];
                if (step_rsp.last) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    char_next     = s_tdata[9:2];
                    addr_next     = s_tdata[20:10];
                    in_range_next = 1'b0;
                    scrolled_next = 1'b0;
                    idx_next      = '0;
                    unique case (s_tdata[1:0])
                        tccw_pkg::MODE_PUT:   state_next = ST_PUT;
                        tccw_pkg::MODE_READ:  state_next = ST_READ;
                        tccw_pkg::MODE_CLEAR: state_next = ST_CLEAR;
                        default:              state_next = ST_DONE;
                    endcase
                end
            end
            ST_PUT: begin
                col_next = put_col_w[CW-1:0];
                if (put_scroll) begin
                    row_next      = RW'(ROWS - 1);
                    scrolled_next = 1'b1;
                    state_next    = ST_SCROLL;
                end else begin
                    row_next   = put_row_w[RW-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                step_req.base = IW'(addr_reg);
                ram_re        = step_rsp.in_range;
                in_range_next = step_rsp.in_range;
                state_next    = ST_DONE;
            end
            ST_CLEAR: begin
                idx_next = step_rsp.nxt[AW-1:0];
                if (step_rsp.last) begin
                    idx_next   = '0;
                    row_next   = '0;
                    col_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL: begin
                // Read one row below, write it back here next cycle
                step_req.add_row = 1'b1;
                ram_re           = step_rsp.in_range;
                pend_next        = 1'b1;
                pend_addr_next   = idx_reg;
                pend_copy_next   = step_rsp.in_range;
                idx_next         = step_rsp.nxt[AW-1:0];
                if (step_rsp.last) begin
                    idx_next   = '0;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, scrolled_reg, out_value,
                                    cur_pos[tccw_pkg::CURSOR_W-1:0]};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    assign out_value = in_range_reg ? ram_rdata : '0;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            idx_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            attr_reg    <= tccw_pkg::RESET_ATTR;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            attr_reg    <= attr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        char_reg      <= char_next;
        addr_reg      <= addr_next;
        in_range_reg  <= in_range_next;
        scrolled_reg  <= scrolled_next;
        pend_addr_reg <= pend_addr_next;
        pend_copy_reg <= pend_copy_next;
        m_data_reg    <= m_data_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> verif/text_console_cell_writer_checker.sv
`timescale 1ns / 1ps

module text_console_cell_writer_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [1:0] mode, [9:2] char_code, [20:10] cell_address
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // [10:0] cursor_position, [26:11] cell_value, [27] scrolled
    output int          outstanding,
    output int          mismatch_count
);

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [tccw_pkg::CURSOR_W-1:0] cursor_position;
        logic [tccw_pkg::CELL_W-1:0]   cell_value;
        logic                          scrolled;
    } console_result_t;

    // Shadow copy of the screen, cursor and attribute
    logic [tccw_pkg::CELL_W-1:0] shadow_screen [CELLS];
    logic [tccw_pkg::ATTR_W-1:0] text_attr;
    int                          cur_row;
    int                          cur_col;

    console_result_t   due_results [$];
    int                err_total = 0;

    function automatic void blank_range(input int from, input int upto);
        for (int i = from; i < upto; i++) begin
            shadow_screen[i] = {text_attr, tccw_pkg::BLANK_GLYPH};
        end
    endfunction

    // Advance the cursor for one character; return whether the screen scrolled
    function automatic logic put_glyph(input logic [tccw_pkg::CHAR_W-1:0] ch);
        logic rolled;
        rolled = 1'b0;
        case (ch)
            tccw_pkg::CHAR_LF: begin
                cur_col = 0;
                cur_row++;
            end
            tccw_pkg::CHAR_CR: begin
                cur_col = 0;
            end
            tccw_pkg::CHAR_TAB: begin
                cur_col = (cur_col + tccw_pkg::TAB_STEP) & ~(tccw_pkg::TAB_STEP - 1);
            end
            tccw_pkg::CHAR_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                    shadow_screen[cur_row * COLUMNS + cur_col] =
                        {text_attr, tccw_pkg::BLANK_GLYPH};
                end
            end
            default: begin
                shadow_screen[cur_row * COLUMNS + cur_col] = {text_attr, ch};
                cur_col++;
            end
        endcase
        // wrap past the last column
        if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
        end
        // scroll up one row past the last row
        if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            end
            blank_range((ROWS - 1) * COLUMNS, CELLS);
            cur_row = ROWS - 1;
            rolled  = 1'b1;
        end
        return rolled;
    endfunction

    function automatic console_result_t step_console(
        input logic [tccw_pkg::MODE_W-1:0] md,
        input logic [tccw_pkg::CHAR_W-1:0] ch,
        input logic [tccw_pkg::ADDR_W-1:0] addr);
        console_result_t res;
        int              pos;
        res = '0;
        case (md)
            tccw_pkg::MODE_PUT: begin
                res.scrolled = put_glyph(ch);
            end
            tccw_pkg::MODE_READ: begin
                if (int'(addr) < CELLS) begin
                    res.cell_value = shadow_screen[addr];
                end
            end
            tccw_pkg::MODE_CLEAR: begin
                blank_range(0, CELLS);
                cur_row = 0;
                cur_col = 0;
            end
            default: ;
        endcase
        pos = cur_row * COLUMNS + cur_col;
        res.cursor_position = pos[tccw_pkg::CURSOR_W-1:0];
        return res;
    endfunction

    // Compare results against the oldest prediction, then predict accepted words
    always @(posedge aclk) begin
        console_result_t got;
        console_result_t want;
        if (!aresetn) begin
            text_attr = tccw_pkg::RESET_ATTR;
            cur_row   = 0;
            cur_col   = 0;
            blank_range(0, CELLS);
            due_results.delete();
        end else begin
            if (cfg_wr_en) begin
                text_attr = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                got.cursor_position = m_tdata[10:0];
                got.cell_value      = m_tdata[26:11];
                got.scrolled        = m_tdata[27];
                if (due_results.size() == 0) begin
                    $error("result word with no prediction waiting: %h", m_tdata);
                    err_total++;
                end else begin
                    want = due_results.pop_front();
                    if (got.cursor_position !== want.cursor_position) begin
                        $error("cursor_position: expected %0d, got %0d",
                               want.cursor_position, got.cursor_position);
                        err_total++;
                    end
                    if (got.cell_value !== want.cell_value) begin
                        $error("cell_value: expected %h, got %h",
                               want.cell_value, got.cell_value);
                        err_total++;
                    end
                    if (got.scrolled !== want.scrolled) begin
                        $error("scrolled: expected %0d, got %0d",
                               want.scrolled, got.scrolled);
                        err_total++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                due_results.push_back(step_console(s_tdata[1:0], s_tdata[9:2],
                                                   s_tdata[20:10]));
            end
        end
        outstanding    <= due_results.size();
        mismatch_count <= err_total;
    end

endmodule

>>> verif/text_console_cell_writer_core_tb.sv
`timescale 1ns / 1ps

module text_console_cell_writer_core_tb;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_WORDS = 170;

    // The block ignores this mode
    localparam logic [tccw_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = 24'd0;   // [1:0] mode, [9:2] char_code, [20:10] cell_address
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;               // [10:0] cursor_position, [26:11] cell_value, [27] scrolled

    int outstanding;
    int mismatch_count;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int console_words = 0;
    logic hold_go     = 1'b0;

    text_console_cell_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    text_console_cell_writer_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Guard against a hung block
    initial begin
        #60ms;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int held;
        bit hold_used;
        hold_used = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go && !hold_used) begin
                hold_used = 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    m_tready <= 1'b0;
                    @(posedge aclk);
                end
            end
            m_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Offer one word, idling first at random, and hold it until taken
    task automatic send_word(input logic [tccw_pkg::MODE_W-1:0] md,
                             input logic [tccw_pkg::CHAR_W-1:0] ch,
                             input logic [tccw_pkg::ADDR_W-1:0] addr);
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, addr, ch, md};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (md != MODE_UNUSED) console_words++;
    endtask

    // Stop offering and wait for every predicted result
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic set_attribute(input logic [7:0] attr);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= attr;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Bursts of text, line feeds, reads, clears and ignored words
    task automatic run_traffic(input int goal);
        int first;
        int pick;
        int n;
        int left;
        logic [tccw_pkg::CHAR_W-1:0] ch;
        logic [tccw_pkg::ADDR_W-1:0] addr;
        first = console_words;
        while (console_words - first < goal) begin
            left = goal - (console_words - first);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                n = $urandom_range(1, 60);
                if (n > left) n = left;
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 99) < 88) begin
                        ch = 8'($urandom_range(0, 255));
                    end else begin
                        case ($urandom_range(0, 3))
                            0:       ch = tccw_pkg::CHAR_LF;
                            1:       ch = tccw_pkg::CHAR_CR;
                            2:       ch = tccw_pkg::CHAR_TAB;
                            default: ch = tccw_pkg::CHAR_BS;
                        endcase
                    end
                    send_word(tccw_pkg::MODE_PUT, ch, 11'($urandom_range(0, 2047)));
                end
            end else if (pick < 60) begin
                // runs of line feeds and carriage returns, at times long enough to reach the bottom row and scroll
                n = $urandom_range(1, 30);
                if (n > left) n = left;
                for (int i = 0; i < n; i++) begin
                    ch = ($urandom_range(0, 99) < 20) ? tccw_pkg::CHAR_CR
                                                       : tccw_pkg::CHAR_LF;
                    send_word(tccw_pkg::MODE_PUT, ch, 11'($urandom_range(0, 2047)));
                end
            end else if (pick < 85) begin
                n = $urandom_range(1, 8);
                if (n > left) n = left;
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 99) < 85) begin
                        addr = 11'($urandom_range(0, CELLS - 1));
                    end else begin
                        addr = 11'($urandom_range(CELLS, 2047));
                    end
                    send_word(tccw_pkg::MODE_READ, 8'($urandom_range(0, 255)), addr);
                end
            end else if (pick < 93) begin
                send_word(tccw_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)),
                          11'($urandom_range(0, 2047)));
            end else begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    send_word(MODE_UNUSED, 8'($urandom_range(0, 255)),
                              11'($urandom_range(0, 2047)));
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: read extremes, glyph extremes, control codes, tab wrap, clear
        send_word(tccw_pkg::MODE_READ, 8'd0, 11'd0);
        send_word(tccw_pkg::MODE_READ, 8'd0, 11'(CELLS - 1));
        send_word(tccw_pkg::MODE_READ, 8'd0, 11'(CELLS));
        send_word(tccw_pkg::MODE_READ, 8'd0, 11'h7FF);
        send_word(tccw_pkg::MODE_PUT, 8'h41, 11'd0);
        send_word(tccw_pkg::MODE_PUT, 8'h00, 11'd0);
        send_word(tccw_pkg::MODE_PUT, 8'hFF, 11'h7FF);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CHAR_BS, 11'd0);
        send_word(tccw_pkg::MODE_READ, 8'd0, 11'd2);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CHAR_CR, 11'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CHAR_BS, 11'd0);
        send_word(MODE_UNUSED, 8'hFF, 11'h7FF);
        repeat (COLUMNS / tccw_pkg::TAB_STEP)
            send_word(tccw_pkg::MODE_PUT, tccw_pkg::CHAR_TAB, 11'd0);
        send_word(tccw_pkg::MODE_PUT, 8'h7E, 11'd0);
        send_word(tccw_pkg::MODE_PUT, tccw_pkg::CHAR_LF, 11'd0);
        send_word(tccw_pkg::MODE_CLEAR, 8'd0, 11'd0);
        send_word(tccw_pkg::MODE_READ, 8'd0, 11'd1);

        // Random phases under varying attributes, idling and result stalls
        run_traffic(PHASE_WORDS);
        drain();

        set_attribute(8'hFF);
        idle_pct = 61;
        run_traffic(PHASE_WORDS);
        drain();

        set_attribute(8'h00);
        idle_pct  = 0;
        stall_pct = 61;
        hold_go  <= 1'b1;
        run_traffic(PHASE_WORDS);
        drain();

        set_attribute(8'($urandom_range(0, 255)));
        idle_pct  = 21;
        stall_pct = 21;
        run_traffic(PHASE_WORDS);
        drain();

        set_attribute(8'($urandom_range(0, 255)));
        idle_pct  = 0;
        stall_pct = 0;
        run_traffic(PHASE_WORDS);
        drain();

        // Allow a full store walk for any stray result
        repeat (CELLS + 64) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
